### rtl/core/wvs_pkg.sv
// wvs_pkg: shared types, constants and codes for the windowed vector stats block.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package wvs_pkg;

    // Fixed geometry of the block
    localparam int CHANNELS    = 6;
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 24;
    localparam int SUM_W       = 40;
    localparam int ELAPSED_W   = 12;
    localparam int CH_IDX_W    = 3;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [COUNT_W-1:0]   COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'b1;

    // Reset values of the registers
    localparam logic [CH_IDX_W-1:0]  VLEN_RESET = 3'd6;
    localparam logic [ELAPSED_W-1:0] WSEC_RESET = 12'd1;

    // Input word kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [LEN_W-1:0]           sample_length;
        logic signed [SAMPLE_W-1:0] elem_0;
        logic signed [SAMPLE_W-1:0] elem_1;
        logic signed [SAMPLE_W-1:0] elem_2;
        logic signed [SAMPLE_W-1:0] elem_3;
        logic signed [SAMPLE_W-1:0] elem_4;
        logic signed [SAMPLE_W-1:0] elem_5;
    } t_in_word;

    typedef struct packed {
        logic [CH_IDX_W-1:0]        channel;
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
        logic [COUNT_W-1:0]         sample_count;
        logic [ELAPSED_W-1:0]       elapsed_seconds;
        logic                       last;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic cap;
        logic tick;
        logic accum;
        logic div_start;
        logic emit;
        logic chan_clr;
        logic chan_inc;
        logic win_clr;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic sample_ok;
        logic report_due;
        logic div_busy;
        logic div_done;
        logic out_free;
        logic chan_last;
    } t_dp_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT,
        S_ACCUM
    } t_state;

endpackage

### rtl/core/wvs_div.sv
// wvs_div: bit-serial restoring divider, signed window sum by unsigned count.
// One quotient bit per cycle; depends on wvs_pkg.
`timescale 1ns / 1ps

module wvs_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [wvs_pkg::SUM_W-1:0]    i_dividend,
    input  logic [wvs_pkg::COUNT_W-1:0]         i_divisor,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [wvs_pkg::SAMPLE_W-1:0] o_quotient
);
    import wvs_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic               r_busy, r_done, r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_dsr;

    logic [SUM_W-1:0]   w_mag;
    logic [COUNT_W:0]   w_trial;
    logic [COUNT_W+1:0] w_diff;
    logic               w_fits;
    logic [SUM_W-1:0]   w_q;

    // magnitude of the dividend; the most negative sum still fits unsigned
    assign w_mag   = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;

    // one restoring step
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dsr};
    assign w_fits  = !w_diff[COUNT_W+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[COUNT_W-1:0] : w_trial[COUNT_W-1:0];
        end
    end

    // truncation toward zero: negate the magnitude quotient
    assign w_q        = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_quotient = w_q[SAMPLE_W-1:0];
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

### rtl/core/wvs_dp.sv
// wvs_dp: datapath - configuration registers, window state, report divider,
// input capture and output register. Depends on wvs_pkg and wvs_div.
`timescale 1ns / 1ps

module wvs_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wvs_pkg::t_in_word                    i_in_word,
    input  logic                                 i_cfg_we,
    input  logic [wvs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wvs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wvs_pkg::t_dp_cmd                     i_cmd,
    output wvs_pkg::t_dp_status                  o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output wvs_pkg::t_out_word                   o_out_word
);
    import wvs_pkg::*;

    logic [CH_IDX_W-1:0]        r_vlen;
    logic [ELAPSED_W-1:0]       r_wsec;
    t_in_word                   r_in;
    logic signed [SUM_W-1:0]    r_sum [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_min [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_max [CHANNELS];
    logic [COUNT_W-1:0]         r_count;
    logic [ELAPSED_W-1:0]       r_elapsed;
    logic [CH_IDX_W-1:0]        r_chan;
    t_out_word                  r_out;
    logic                       r_out_valid;

    logic signed [SAMPLE_W-1:0] w_elem [CHANNELS];
    logic                       w_clear;
    logic                       w_div_busy, w_div_done;
    logic signed [SAMPLE_W-1:0] w_mean;

    assign w_elem[0] = r_in.elem_0;
    assign w_elem[1] = r_in.elem_1;
    assign w_elem[2] = r_in.elem_2;
    assign w_elem[3] = r_in.elem_3;
    assign w_elem[4] = r_in.elem_4;
    assign w_elem[5] = r_in.elem_5;

    // window is wiped at the end of a report or on a new vector length
    assign w_clear = i_cmd.win_clr || (i_cfg_we && i_cfg_index == CFG_VECTOR_LENGTH);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= VLEN_RESET;
            r_wsec <= WSEC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VECTOR_LENGTH:  r_vlen <= i_cfg_data[CH_IDX_W-1:0];
                CFG_WINDOW_SECONDS: r_wsec <= i_cfg_data[ELAPSED_W-1:0];
                default:            ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) r_in <= i_in_word;
    end

    // window count and elapsed seconds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_count   <= '0;
            r_elapsed <= '0;
        end else begin
            if (i_cmd.tick && r_count != '0 && r_elapsed != ELAPSED_MAX)
                r_elapsed <= r_elapsed + ELAPSED_W'(1);
            if (i_cmd.accum && r_count != COUNT_MAX)
                r_count <= r_count + COUNT_W'(1);
        end
    end

    // per-channel sum, minimum and maximum; lanes are independent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
                r_min[c] <= '0;
                r_max[c] <= '0;
            end
        end else if (i_cmd.accum && r_count != COUNT_MAX) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (CH_IDX_W'(c) < r_vlen) begin
                    r_sum[c] <= r_sum[c]
                              + {{(SUM_W-SAMPLE_W){w_elem[c][SAMPLE_W-1]}}, w_elem[c]};
                    if (r_count == '0) begin
                        r_min[c] <= w_elem[c];
                        r_max[c] <= w_elem[c];
                    end else begin
                        if (w_elem[c] < r_min[c]) r_min[c] <= w_elem[c];
                        if (w_elem[c] > r_max[c]) r_max[c] <= w_elem[c];
                    end
                end
            end
        end
    end

    // report channel pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.chan_clr) begin
            r_chan <= '0;
        end else if (i_cmd.chan_inc) begin
            r_chan <= r_chan + CH_IDX_W'(1);
        end
    end

    // mean of the channel being reported
    wvs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum[r_chan]),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_mean)
    );

    // output register: a report word waits here while the next is worked out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.channel         <= r_chan;
            r_out.mean            <= w_mean;
            r_out.minimum         <= r_min[r_chan];
            r_out.maximum         <= r_max[r_chan];
            r_out.sample_count    <= r_count;
            r_out.elapsed_seconds <= r_elapsed;
            r_out.last            <= o_status.chan_last;
        end
    end

    // status back to the controller
    always_comb begin
        o_status.is_tick    = (r_in.mode == MODE_TICK);
        o_status.sample_ok  = (r_in.mode == MODE_SAMPLE)
                           && (r_in.sample_length == {1'b0, r_vlen})
                           && (r_vlen != '0)
                           && (r_vlen <= CH_IDX_W'(CHANNELS));
        o_status.report_due = (r_count != '0) && (r_elapsed >= r_wsec);
        o_status.div_busy   = w_div_busy;
        o_status.div_done   = w_div_done;
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.chan_last  = (r_chan == r_vlen - CH_IDX_W'(1));
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### rtl/core/wvs_ctrl.sv
// wvs_ctrl: controller state machine - word acceptance, report sequencing,
// accumulation. Depends on wvs_pkg.
`timescale 1ns / 1ps

module wvs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wvs_pkg::t_dp_status  i_status,
    output wvs_pkg::t_dp_cmd     o_cmd
);
    import wvs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.is_tick || !i_status.sample_ok) n_state = S_IDLE;
                else if (i_status.report_due)               n_state = S_DIV_GO;
                else                                         n_state = S_IDLE;
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_status.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free)
                    n_state = i_status.chan_last ? S_ACCUM : S_DIV_GO;
            end
            S_ACCUM:    n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.chan_clr = 1'b1;
                if (i_status.is_tick)
                    o_cmd.tick = 1'b1;
                else if (i_status.sample_ok && !i_status.report_due)
                    o_cmd.accum = 1'b1;
            end
            S_DIV_GO:   o_cmd.div_start = 1'b1;
            S_DIV_WAIT: ;
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.chan_last) o_cmd.win_clr  = 1'b1;
                    else                    o_cmd.chan_inc = 1'b1;
                end
            end
            S_ACCUM:    o_cmd.accum = 1'b1;
            default:    ;
        endcase
    end

endmodule

### rtl/core/windowed_vector_stats.sv
// windowed_vector_stats: top level joining controller and datapath.
// Depends on wvs_pkg, wvs_ctrl, wvs_dp (and wvs_div below it).
`timescale 1ns / 1ps

// Accepts one word at a time: a sample vector or a one-second tick. A tick, a
// dropped vector or a sample that only accumulates passes through accept, then
// execute, before the next word is taken. A sample that closes a window first
// reports every active channel; each report word waits on the bit-serial divider
// that forms the mean (40 quotient bits, one a cycle, after a start state), and
// waits in the output register if the sink stalls. The closing sample is then
// added in the accumulate state. All window state lives in flip-flops and is
// cleared by reset at once; no clearing pass.
// Configuration writes are taken at any cycle but belong in idle periods; a
// write to vector_length clears the window.

module windowed_vector_stats (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  wvs_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output wvs_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_we,
    input  logic [wvs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wvs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wvs_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    wvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wvs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // a report word is only loaded into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("report word loaded over an unread one");

    // the divider is never restarted mid-division
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_status.div_busy)
        else $error("divider restarted while busy");

    // accumulation never runs over a window that is due for a report
    a_accum_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accum |-> !w_status.report_due)
        else $error("sample accumulated into a window due for report");

    // the final report word clears the window before the sample is added
    a_clear_then_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.win_clr |=> w_cmd.accum)
        else $error("window cleared without adding the closing sample");

endmodule

### tb/sv/testbench.sv
// testbench: self-checking bench for windowed_vector_stats.
// Depends on wvs_pkg and the RTL under rtl/core; an in-bench window model predicts each report.
`timescale 1ns / 1ps

module testbench;
    import wvs_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int TAIL_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 55;

    // Block ports; the inputs are driven to known values from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Idling percentages, changed per phase
    int send_idle_pct = 17;
    int recv_idle_pct = 82;

    int cycle_count = 0;
    int mismatches  = 0;

    // Window model
    logic [2:0]                 vec_len;
    logic [ELAPSED_W-1:0]       win_secs;
    logic signed [SUM_W-1:0]    chan_sum [CHANNELS];
    logic signed [SAMPLE_W-1:0] chan_min [CHANNELS];
    logic signed [SAMPLE_W-1:0] chan_max [CHANNELS];
    logic [COUNT_W-1:0]         win_count;
    logic [ELAPSED_W-1:0]       win_elapsed;

    t_out_word expected_reports[$];
    t_out_word want;

    windowed_vector_stats u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sink side: random back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Window model: clear sums, extremes, count and elapsed time
    function automatic void clear_window_stats();
        for (int c = 0; c < CHANNELS; c++) begin
            chan_sum[c] = '0;
            chan_min[c] = '0;
            chan_max[c] = '0;
        end
        win_count   = '0;
        win_elapsed = '0;
    endfunction

    // Window model: one accepted word, pushing any reports it closes out
    function automatic void predict_window_stats(input t_in_word w);
        logic signed [SAMPLE_W-1:0] elems [CHANNELS];
        t_out_word r;
        longint    q;
        int        len;
        elems = '{w.elem_0, w.elem_1, w.elem_2, w.elem_3, w.elem_4, w.elem_5};
        if (w.mode == MODE_TICK) begin
            if (win_count != 0 && win_elapsed != ELAPSED_MAX)
                win_elapsed = win_elapsed + 1'b1;
            return;
        end
        if (w.sample_length != {1'b0, vec_len})
            return;
        if (vec_len == 0 || vec_len > CHANNELS)
            return;
        len = vec_len;
        // Window due: report every active channel, then start afresh
        if (win_count != 0 && win_elapsed >= win_secs) begin
            for (int c = 0; c < len; c++) begin
                q = longint'(chan_sum[c]) / longint'(win_count);
                r.channel         = 3'(c);
                r.mean            = q[SAMPLE_W-1:0];
                r.minimum         = chan_min[c];
                r.maximum         = chan_max[c];
                r.sample_count    = win_count;
                r.elapsed_seconds = win_elapsed;
                r.last            = (c == len - 1);
                expected_reports.push_back(r);
            end
            clear_window_stats();
        end
        // Saturated count: the sample is ignored
        if (win_count == COUNT_MAX)
            return;
        for (int c = 0; c < len; c++) begin
            chan_sum[c] = chan_sum[c] + elems[c];
            if (win_count == 0) begin
                chan_min[c] = elems[c];
                chan_max[c] = elems[c];
            end else begin
                if (elems[c] < chan_min[c]) chan_min[c] = elems[c];
                if (elems[c] > chan_max[c]) chan_max[c] = elems[c];
            end
        end
        win_count = win_count + 1'b1;
    endfunction

    // Report checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report word: ",
                             "ch %0d mean %0d min %0d max %0d cnt %0d sec %0d last %0b",
                             o_out_word.channel, o_out_word.mean, o_out_word.minimum,
                             o_out_word.maximum, o_out_word.sample_count,
                             o_out_word.elapsed_seconds, o_out_word.last);
            end else begin
                want = expected_reports.pop_front();
                if (o_out_word.channel !== want.channel || o_out_word.mean !== want.mean
                    || o_out_word.minimum !== want.minimum
                    || o_out_word.maximum !== want.maximum
                    || o_out_word.sample_count !== want.sample_count
                    || o_out_word.elapsed_seconds !== want.elapsed_seconds
                    || o_out_word.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("report mismatch exp: ",
                                 "ch %0d mean %0d min %0d max %0d cnt %0d sec %0d last %0b",
                                 want.channel, want.mean, want.minimum, want.maximum,
                                 want.sample_count, want.elapsed_seconds, want.last);
                        $display("                got: ",
                                 "ch %0d mean %0d min %0d max %0d cnt %0d sec %0d last %0b",
                                 o_out_word.channel, o_out_word.mean, o_out_word.minimum,
                                 o_out_word.maximum, o_out_word.sample_count,
                                 o_out_word.elapsed_seconds, o_out_word.last);
                    end
                end
            end
        end
    end

    // Random element, weighted towards the extremes and small values
    function automatic logic signed [SAMPLE_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 32)) - 16'd16;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_in_word make_vector(input int len,
                                             input logic signed [SAMPLE_W-1:0] e0, e1, e2,
                                             input logic signed [SAMPLE_W-1:0] e3, e4, e5);
        t_in_word w;
        w.mode          = MODE_SAMPLE;
        w.sample_length = 4'(len);
        w.elem_0 = e0;
        w.elem_1 = e1;
        w.elem_2 = e2;
        w.elem_3 = e3;
        w.elem_4 = e4;
        w.elem_5 = e5;
        return w;
    endfunction

    function automatic t_in_word rand_vector(input int len);
        return make_vector(len, rand_elem(), rand_elem(), rand_elem(),
                           rand_elem(), rand_elem(), rand_elem());
    endfunction

    // Tick with junk in the ignored fields
    function automatic t_in_word make_tick();
        t_in_word w;
        w = rand_vector($urandom_range(0, 15));
        w.mode = MODE_TICK;
        return w;
    endfunction

    // Send one word; starts at the next falling edge, returns at the accepting edge
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_window_stats(w);
    endtask

    // Stop sending and let every expected report and trailing work finish
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write; called at a falling edge while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_VECTOR_LENGTH) begin
            vec_len = data[2:0];
            clear_window_stats();
        end else if (idx == CFG_WINDOW_SECONDS) begin
            win_secs = data[ELAPSED_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reset settings: length 6, one-second window, extreme values and truncation
    task automatic test_reset_state();
        send_word(make_tick());
        send_word(make_vector(6, 16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh0400));
        send_word(make_vector(6, 16'sh8000, 16'sh7FFF, -16'sd3, 16'sd0, 16'sd2, -16'sh0400));
        send_word(make_tick());
        send_word(make_tick());
        send_word(make_vector(6, 16'sd5, -16'sd5, 16'sd7, 16'sh7FFF, 16'sh8000, 16'sd0));
    endtask

    // Wrong element counts are dropped; a correct one afterwards reports
    task automatic test_length_mismatch();
        send_word(rand_vector(0));
        send_word(rand_vector(5));
        send_word(rand_vector(7));
        send_word(rand_vector(15));
        send_word(make_tick());
        send_word(rand_vector(6));
    endtask

    // Zero threshold: every valid sample reports the window before it
    task automatic test_zero_threshold();
        drain();
        write_reg(CFG_WINDOW_SECONDS, 12'd0);
        send_word(rand_vector(6));
        send_word(rand_vector(6));
        send_word(rand_vector(6));
    endtask

    // Lengths of zero and beyond the channel count drop everything
    task automatic test_bad_vector_length();
        drain();
        write_reg(CFG_VECTOR_LENGTH, 12'd0);
        send_word(rand_vector(0));
        send_word(rand_vector(6));
        drain();
        write_reg(CFG_VECTOR_LENGTH, 12'd7);
        send_word(rand_vector(7));
        drain();
        write_reg(CFG_VECTOR_LENGTH, 12'd1);
        send_word(rand_vector(1));
        send_word(rand_vector(1));
    endtask

    // A length write, even of the same value, empties the window
    task automatic test_length_write_clears();
        drain();
        write_reg(CFG_VECTOR_LENGTH, 12'd3);
        write_reg(CFG_WINDOW_SECONDS, 12'd1);
        send_word(rand_vector(3));
        send_word(rand_vector(3));
        send_word(make_tick());
        drain();
        write_reg(CFG_VECTOR_LENGTH, 12'd3);
        send_word(make_tick());
        send_word(rand_vector(3));
        send_word(make_tick());
        send_word(rand_vector(3));
    endtask

    // Random windows: mostly good samples and ticks, some broken lengths
    task automatic test_random_windows(input int items);
        int sent;
        int burst;
        int roll;
        sent = 0;
        while (sent < items) begin
            drain();
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_VECTOR_LENGTH, 12'($urandom_range(1, CHANNELS)));
            case ($urandom_range(0, 9))
                0, 1, 2: write_reg(CFG_WINDOW_SECONDS, 12'd0);
                3, 4, 5: write_reg(CFG_WINDOW_SECONDS, 12'd1);
                6, 7:    write_reg(CFG_WINDOW_SECONDS, 12'd2);
                8:       write_reg(CFG_WINDOW_SECONDS, 12'd3);
                default: write_reg(CFG_WINDOW_SECONDS, 12'd3600);
            endcase
            burst = $urandom_range(8, 16);
            for (int k = 0; k < burst; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 65)
                    send_word(rand_vector(vec_len));
                else if (roll < 88)
                    send_word(make_tick());
                else
                    send_word(rand_vector($urandom_range(0, 15)));
            end
            sent += burst;
        end
    endtask

    initial begin
        vec_len  = VLEN_RESET;
        win_secs = WSEC_RESET;
        clear_window_stats();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender mostly busy, sink mostly stalled
        test_reset_state();
        test_length_mismatch();
        test_zero_threshold();
        test_bad_vector_length();
        test_length_write_clears();
        test_random_windows(RANDOM_ITEMS);

        // Sender mostly idle, sink mostly ready
        send_idle_pct = 82;
        recv_idle_pct = 17;
        test_random_windows(RANDOM_ITEMS);

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_windows(RANDOM_ITEMS);

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
